// ===== sv/color_gradient_interpolator_top_defines.svh =====
// ----------------------------------------------------------------------------
// Color gradient interpolator assertion macros
// Shared concurrent assertion forms for the gradient interpolator RTL.
// ----------------------------------------------------------------------------
`ifndef COLOR_GRADIENT_INTERPOLATOR_TOP_DEFINES_SVH
`define COLOR_GRADIENT_INTERPOLATOR_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CGI_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gradient interpolator: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CGI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gradient interpolator: next-cycle check failed");

`endif

// ===== sv/cgi_pkg.sv =====
// ----------------------------------------------------------------------------
// Color gradient interpolator package
// Widths, constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package cgi_pkg;

    localparam int KEYS_DEFAULT = 16;

    localparam int POS_W   = 16;   // unsigned Q0.16 position
    localparam int CHAN_W  = 16;   // signed Q4.12 channel
    localparam int CHANS   = 4;
    localparam int CNT_W   = 5;    // key_count register
    localparam int KIDX_W  = 4;    // key_index field
    localparam int ENTRY_W = POS_W + CHANS * CHAN_W;

    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = CHANS * CHAN_W;

    // slave tdata field offsets
    localparam int OFS_KIDX   = 0;
    localparam int OFS_KPOS   = OFS_KIDX + KIDX_W;
    localparam int OFS_KCOLOR = OFS_KPOS + POS_W;
    localparam int OFS_SPOS   = OFS_KCOLOR + CHANS * CHAN_W;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_WRITE  = 1'b1;

    localparam logic [CHAN_W-1:0] ONE_Q412 = 16'h1000;

    typedef struct packed {
        logic wr;          // store key entry
        logic start;       // latch sample position, restart search at key 0
        logic ones;        // result = 1.0 on all channels
        logic take_rd;     // result = color of key under compare
        logic advance;     // step search to next key
        logic div_start;
        logic div_step;
        logic mul;
        logic add;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic n_zero;      // table empty
        logic le;          // sample position <= key position under compare
        logic idx_zero;
        logic last;        // key under compare is the last valid one
        logic div_last;
        logic ch_last;
        logic out_free;
    } t_sts;

endpackage

// ===== sv/color_gradient_interpolator_top.sv =====
// ----------------------------------------------------------------------------
// Color gradient interpolator
// Piecewise linear color gradient lookup over a table of sorted keys.
// ----------------------------------------------------------------------------
// A key write (tuser = 1) is stored from the idle state and yields no result. A
// sample (tuser = 0) compares the keys one per cycle out of the key memory,
// starting at key 0, and stops at the first key at or above the sample position
// or at the last valid key. A sample that lands on an end of the gradient (or
// an empty table) takes its result directly; an interior sample runs 16 steps
// of the restoring divider for the blend factor, then the shared multiplier and
// adder do one multiply and one add for each of the four channels. The slave
// side is ready again the cycle after the result moves into the output
// register, which holds it until it is taken.
module color_gradient_interpolator_top #(
    parameter int KEYS = cgi_pkg::KEYS_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [cgi_pkg::CNT_W-1:0]     i_cfg_wr_data,    // key_count
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // key_index, key_pos, key_red, key_green, key_blue, key_alpha, sample_pos
    input  logic [cgi_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    input  logic                          i_s_axis_tuser,   // mode
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // out_red, out_green, out_blue, out_alpha
    output logic [cgi_pkg::M_TDATA_W-1:0] o_m_axis_tdata
);
    import cgi_pkg::*;

    t_cmd cmd;
    t_sts sts;

    cgi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_mode  (i_s_axis_tuser),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    cgi_datapath #(
        .KEYS (KEYS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_data     (i_s_axis_tdata),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_out_data    (o_m_axis_tdata)
    );

endmodule

// ===== sv/cgi_datapath.sv =====
// ----------------------------------------------------------------------------
// Color gradient interpolator datapath
// Key memory, search registers, restoring divider, shared channel multiplier
// and output register.
// ----------------------------------------------------------------------------
module cgi_datapath #(
    parameter int KEYS = cgi_pkg::KEYS_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [cgi_pkg::CNT_W-1:0]     i_cfg_wr_data,
    input  logic [cgi_pkg::S_TDATA_W-1:0] i_in_data,
    input  cgi_pkg::t_cmd                 i_cmd,
    output cgi_pkg::t_sts                 o_sts,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [cgi_pkg::M_TDATA_W-1:0] o_out_data
);
    import cgi_pkg::*;

    localparam int AW  = $clog2(KEYS);
    localparam int IW  = $clog2(KEYS + 1);
    localparam int DCW = $clog2(POS_W);

    logic [CNT_W-1:0]       r_key_count;
    logic [IW-1:0]          n_keys;
    logic [IW-1:0]          r_idx, n_idx;
    logic [ENTRY_W-1:0]     mem [KEYS];
    logic [ENTRY_W-1:0]     r_rd, r_prev;
    logic [POS_W-1:0]       r_t;
    logic [KIDX_W-1:0]      in_kidx;
    logic [ENTRY_W-1:0]     in_entry;
    logic                   wr_ok;

    logic [POS_W-1:0]       rd_pos, prev_pos, num, den;
    logic [POS_W:0]         r_rem, rem2;
    logic [POS_W-1:0]       r_den, r_q;
    logic                   r_full, ge;
    logic [DCW-1:0]         r_dcnt;
    logic [POS_W:0]         fac;

    logic [1:0]                   r_ch;
    logic [CHAN_W-1:0]            ch_a, ch_b;
    logic signed [CHAN_W:0]       diff;
    logic signed [2*CHAN_W+2:0]   prod;
    logic [CHAN_W-1:0]            r_prod;
    logic [M_TDATA_W-1:0]         r_res;
    logic                         r_ovalid;
    logic [M_TDATA_W-1:0]         r_odata;

    assign in_kidx  = i_in_data[OFS_KIDX +: KIDX_W];
    assign in_entry = {i_in_data[OFS_KCOLOR +: CHANS*CHAN_W], i_in_data[OFS_KPOS +: POS_W]};
    assign wr_ok    = (32'(in_kidx) < KEYS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= '0;
        end else if (i_cfg_wr_en) begin
            r_key_count <= i_cfg_wr_data;
        end
    end

    // a count beyond the table acts as a full table
    assign n_keys = (32'(r_key_count) > KEYS) ? IW'(KEYS) : IW'(r_key_count);

    always_comb begin
        n_idx = r_idx;
        if (i_cmd.start) begin
            n_idx = '0;
        end else if (i_cmd.advance) begin
            n_idx = r_idx + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

    // read address follows the next index so the entry is ready on the compare
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && wr_ok) begin
            mem[AW'(in_kidx)] <= in_entry;
        end
        r_rd <= mem[n_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_t <= i_in_data[OFS_SPOS +: POS_W];
        end
        if (i_cmd.advance) begin
            r_prev <= r_rd;
        end
    end

    // restoring divider: f = (num << 16) / den, num <= den
    assign rd_pos   = r_rd[POS_W-1:0];
    assign prev_pos = r_prev[POS_W-1:0];
    assign num      = r_t - prev_pos;
    assign den      = rd_pos - prev_pos;
    assign rem2     = {r_rem[POS_W-1:0], 1'b0};
    assign ge       = (rem2 >= {1'b0, r_den});
    assign fac      = r_full ? {1'b1, {POS_W{1'b0}}} : {1'b0, r_q};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem  <= {1'b0, num};
            r_den  <= den;
            r_full <= (num == den);
            r_q    <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= ge ? (rem2 - {1'b0, r_den}) : rem2;
            r_q    <= {r_q[POS_W-2:0], ge};
            r_dcnt <= r_dcnt + DCW'(1);
        end
    end

    assign ch_a = r_prev[POS_W + CHAN_W*r_ch +: CHAN_W];
    assign ch_b = r_rd[POS_W + CHAN_W*r_ch +: CHAN_W];
    assign diff = $signed({ch_b[CHAN_W-1], ch_b}) - $signed({ch_a[CHAN_W-1], ch_a});
    assign prod = diff * $signed({1'b0, fac});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch <= '0;
        end else if (i_cmd.div_start) begin
            r_ch <= '0;
        end else if (i_cmd.add) begin
            r_ch <= r_ch + 2'd1;
        end
    end

    // floor(prod / 65536) mod 2^16 is just the middle slice
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= prod[2*CHAN_W-1:CHAN_W];
        end
        if (i_cmd.ones) begin
            r_res <= {CHANS{ONE_Q412}};
        end else if (i_cmd.take_rd) begin
            r_res <= r_rd[ENTRY_W-1:POS_W];
        end else if (i_cmd.add) begin
            r_res[CHAN_W*r_ch +: CHAN_W] <= ch_a + r_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_odata <= r_res;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_odata;

    always_comb begin
        o_sts.n_zero   = (n_keys == '0);
        o_sts.le       = (r_t <= rd_pos);
        o_sts.idx_zero = (r_idx == '0);
        o_sts.last     = (({1'b0, r_idx} + (IW+1)'(1)) >= {1'b0, n_keys});
        o_sts.div_last = (r_dcnt == DCW'(POS_W - 1));
        o_sts.ch_last  = (r_ch == 2'(CHANS - 1));
        o_sts.out_free = !r_ovalid || i_out_ready;
    end

endmodule

// ===== sv/cgi_ctrl.sv =====
// ----------------------------------------------------------------------------
// Color gradient interpolator controller
// Sequences key writes, key search, division, channel blend and output.
// ----------------------------------------------------------------------------
`include "color_gradient_interpolator_top_defines.svh"

module cgi_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_mode,
    output logic          o_in_ready,
    input  cgi_pkg::t_sts i_sts,
    output cgi_pkg::t_cmd o_cmd
);
    import cgi_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CMP  = 6'b000010,
        S_DIV  = 6'b000100,
        S_MUL  = 6'b001000,
        S_ADD  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_mode == MODE_WRITE) begin
                        o_cmd.wr = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        if (i_sts.n_zero) begin
                            o_cmd.ones = 1'b1;
                            n_state    = S_OUT;
                        end else begin
                            n_state = S_CMP;
                        end
                    end
                end
            end
            S_CMP: begin
                if (i_sts.le) begin
                    if (i_sts.idx_zero) begin
                        o_cmd.take_rd = 1'b1;
                        n_state       = S_OUT;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV;
                    end
                end else if (i_sts.last) begin
                    // past the last key: hold its color
                    o_cmd.take_rd = 1'b1;
                    n_state       = S_OUT;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = i_sts.ch_last ? S_OUT : S_MUL;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `CGI_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, o_cmd.load_out, i_sts.out_free)
    `CGI_ASSERT_NEXT(a_div_to_mul, i_clk, i_rst_n, (r_state == S_DIV) && i_sts.div_last, r_state == S_MUL)
    `CGI_ASSERT_NEXT(a_empty_direct, i_clk, i_rst_n, accept && (i_in_mode == MODE_SAMPLE) && i_sts.n_zero, r_state == S_OUT)

endmodule
